/* hdl/s1tsg_pkg.sv */
package s1tsg_pkg;

  localparam int unsigned NumRounds = 80;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 48;

  localparam logic [63:0] LcgMul  = 64'h5d588b656c078965;
  localparam logic [63:0] LcgAdd  = 64'h0000000000269ec3;
  localparam logic [31:0] KeyBase = 32'hff2f0000;
  localparam logic [31:0] PadWord = 32'h80000000;
  localparam logic [31:0] LenWord = 32'h000001a0;
  localparam logic [31:0] OffSeq  = 32'h00000054;
  localparam logic [31:0] OffA    = 32'h000000fc;
  localparam logic [31:0] OffB    = 32'h00000148;

  localparam logic [31:0] Iv0 = 32'h67452301;
  localparam logic [31:0] Iv1 = 32'hefcdab89;
  localparam logic [31:0] Iv2 = 32'h98badcfe;
  localparam logic [31:0] Iv3 = 32'h10325476;
  localparam logic [31:0] Iv4 = 32'hc3d2e1f0;

  // Reciprocals for the time split and the weekday; all three estimates are at most one too low.
  localparam logic [15:0] RecipHour = 16'd37282;
  localparam logic [10:0] RecipMin  = 11'd1092;
  localparam logic [7:0]  RecipWeek = 8'd147;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LANGUAGE = 3'd0,
    REG_VERSION  = 3'd1,
    REG_CONSOLE  = 3'd2,
    REG_VCOUNT   = 3'd3,
    REG_MAC      = 3'd4,
    REG_FRAME    = 3'd5,
    REG_STATUS   = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [2:0]  language;
    logic [1:0]  game_version;
    logic [1:0]  console_type;
    logic [7:0]  vcount;
    logic [47:0] mac_address;
    logic [6:0]  frame_value;
    logic [6:0]  status_value;
  } cfg_t;

  typedef struct packed {
    logic [6:0]  year_in_century;
    logic [3:0]  month_number;
    logic [4:0]  day_of_month;
    logic [16:0] second_of_day;
    logic [11:0] key_mask;
    logic [15:0] timer_value;
  } item_t;

  typedef struct packed {
    logic             vld;
    logic             ok;
    logic [31:0]      a;
    logic [31:0]      b;
    logic [31:0]      c;
    logic [31:0]      d;
    logic [31:0]      e;
    logic [15:0][31:0] w;
  } rnd_t;

  function automatic logic [31:0] bswap32(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [17:0] p;
    logic [3:0]  t;
    logic [6:0]  u;
    p = 18'(v) * 18'd205;
    t = p[14:11];
    u = v - 7'(t) * 7'd10;
    return {t, u[3:0]};
  endfunction

  // Days before the month, modulo 7, for a common year.
  function automatic logic [2:0] month_off(input logic [3:0] m);
    logic [2:0] r;
    unique case (m)
      4'd2:    r = 3'd3;
      4'd3:    r = 3'd3;
      4'd4:    r = 3'd6;
      4'd5:    r = 3'd1;
      4'd6:    r = 3'd4;
      4'd7:    r = 3'd6;
      4'd8:    r = 3'd2;
      4'd9:    r = 3'd5;
      4'd11:   r = 3'd3;
      4'd12:   r = 3'd5;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] r;
    unique case (m)
      4'd2:    r = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
      default: r = 5'd31;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] base_word(input logic alt, input logic [2:0] lang,
                                            input logic [1:0] ver);
    logic [127:0] row;
    if (!alt) begin
      unique case (lang)
        3'd0:    row = {32'h02200050, 32'h02200010, 32'h022160d0, 32'h022160b0};
        3'd1:    row = {32'h021ffff0, 32'h021fffd0, 32'h02216070, 32'h02216070};
        3'd2:    row = {32'h02200050, 32'h02200030, 32'h02216050, 32'h02216030};
        3'd3:    row = {32'h021fff50, 32'h021fff10, 32'h02215fd0, 32'h02215fb0};
        3'd4:    row = {32'h021fff70, 32'h021fff50, 32'h02216010, 32'h02215ff0};
        3'd5:    row = {32'h021ff9d0, 32'h021ff9b0, 32'h02215f30, 32'h02215f10};
        default: row = {32'h02200770, 32'h02200750, 32'h022167b0, 32'h022167b0};
      endcase
    end else begin
      unique case (lang)
        3'd0:    row = {32'h027a5e90, 32'h027a5f70, 32'h027601b0, 32'h02760190};
        3'd1:    row = {32'h027a5fb0, 32'h027a6070, 32'h027601f0, 32'h027601f0};
        3'd2:    row = {32'h027a5ef0, 32'h027a5f90, 32'h02760250, 32'h02760230};
        3'd3:    row = {32'h027a5ed0, 32'h027a5f70, 32'h027601d0, 32'h027601d0};
        3'd4:    row = {32'h027a6010, 32'h027a6110, 32'h027602f0, 32'h027602f0};
        3'd5:    row = {32'h027aa5f0, 32'h027aa730, 32'h02761150, 32'h02761150};
        default: row = {32'h027a57b0, 32'h02200770, 32'h02761150, 32'h02761150};
      endcase
    end
    return row[ver*32 +: 32];
  endfunction

  function automatic logic [31:0] seq0_word(input logic [2:0] lang, input logic hi);
    logic [63:0] row;
    unique case (lang)
      3'd0:    row = {32'h0209af28, 32'h0209aee8};
      3'd1:    row = {32'h0209aec8, 32'h0209aea8};
      3'd2:    row = {32'h0209af28, 32'h0209af08};
      3'd3:    row = {32'h0209ae28, 32'h0209ade8};
      3'd4:    row = {32'h0209ae48, 32'h0209ae28};
      3'd5:    row = {32'h0209a8fc, 32'h0209a8dc};
      default: row = {32'h0209b62c, 32'h0209b60c};
    endcase
    return hi ? row[63:32] : row[31:0];
  endfunction

  function automatic logic [31:0] seq1_word(input logic [2:0] lang, input logic hi);
    logic [63:0] row;
    unique case (lang)
      3'd0:    row = {32'h02039e15, 32'h02039de9};
      3'd1:    row = {32'h02039de5, 32'h02039db9};
      3'd2:    row = {32'h02039e25, 32'h02039df9};
      3'd3:    row = {32'h02039d95, 32'h02039d69};
      3'd4:    row = {32'h02039d95, 32'h02039d69};
      3'd5:    row = {32'h02039af5, 32'h02039ac9};
      default: row = {32'h0203a501, 32'h0203a4d5};
    endcase
    return hi ? row[63:32] : row[31:0];
  endfunction

endpackage

/* hdl/s1tsg_if.sv */
interface s1tsg_in_if;
  logic        valid;
  logic        ready;
  logic [6:0]  year_in_century;
  logic [3:0]  month_number;
  logic [4:0]  day_of_month;
  logic [16:0] second_of_day;
  logic [11:0] key_mask;
  logic [15:0] timer_value;

  modport source (output valid, year_in_century, month_number, day_of_month,
                  second_of_day, key_mask, timer_value, input ready);
  modport sink (input valid, year_in_century, month_number, day_of_month,
                second_of_day, key_mask, timer_value, output ready);
endinterface

interface s1tsg_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] seed;
  logic        valid_res;

  modport source (output valid, seed, valid_res, input ready);
  modport sink (input valid, seed, valid_res, output ready);
endinterface

/* hdl/s1tsg_msg.sv */
module s1tsg_msg
  import s1tsg_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  vld_i,
  input  item_t item_i,
  input  cfg_t  cfg_i,
  output rnd_t  rnd_o
);

  // Four stages: hour estimate, hour correction, minute estimate, message assembly.
  logic        v1_q, v2_q, v3_q;
  item_t       it1_q, it2_q, it3_q;
  logic [32:0] hprod_q;
  logic [5:0]  hour2_q, hour3_q;
  logic [11:0] rem2_q, rem3_q;
  logic [22:0] mprod_q;
  rnd_t        rnd_q;

  logic [5:0]  h_est;
  logic [16:0] h_rem;
  logic [5:0]  hour_d;
  logic [11:0] rem_d;
  logic [5:0]  m_est;
  logic [11:0] s_rem;
  logic [5:0]  min_v;
  logic [5:0]  sec_v;
  logic        leap, ok;
  logic [7:0]  wk_sum;
  logic [15:0] wk_prod;
  logic [7:0]  wk_rem;
  logic [2:0]  dow;
  logic [31:0] base, key, w9;
  logic [1:0]  ver;
  rnd_t        rnd_d;

  always_comb begin
    h_est = hprod_q[32:27];
    h_rem = it1_q.second_of_day - 17'(h_est) * 17'd3600;
    if (h_rem >= 17'd3600) begin
      hour_d = h_est + 6'd1;
      rem_d  = 12'(h_rem - 17'd3600);
    end else begin
      hour_d = h_est;
      rem_d  = h_rem[11:0];
    end
  end

  always_comb begin
    m_est = mprod_q[21:16];
    s_rem = rem3_q - 12'(m_est) * 12'd60;
    if (s_rem >= 12'd60) begin
      min_v = m_est + 6'd1;
      sec_v = 6'(s_rem - 12'd60);
    end else begin
      min_v = m_est;
      sec_v = s_rem[5:0];
    end

    leap = (it3_q.year_in_century[1:0] == 2'd0);
    ok   = (it3_q.year_in_century <= 7'd99) && (it3_q.month_number >= 4'd1) &&
           (it3_q.month_number <= 4'd12) && (it3_q.day_of_month >= 5'd1) &&
           (it3_q.day_of_month <= month_len(it3_q.month_number, leap));

    // Weekday counted from a Saturday at the start of the century.
    wk_sum  = 8'd5 + 8'(it3_q.year_in_century) + 8'((it3_q.year_in_century + 7'd3) >> 2) +
              8'(month_off(it3_q.month_number)) +
              8'(leap && (it3_q.month_number > 4'd2)) + 8'(it3_q.day_of_month);
    wk_prod = 16'(wk_sum) * 16'(RecipWeek);
    wk_rem  = wk_sum - 8'(wk_prod[15:10]) * 8'd7;
    dow     = (wk_rem >= 8'd7) ? 3'(wk_rem - 8'd7) : wk_rem[2:0];

    key = KeyBase - ({cfg_i.language[0] & 1'b0, 31'd0} |
          ({it3_q.key_mask[11:4], 24'd0} + {12'd0, it3_q.key_mask[3:0], 16'd0}));

    w9 = {to_bcd(7'(hour3_q)), to_bcd(7'(min_v)), to_bcd(7'(sec_v)), 8'd0};
    if (hour3_q >= 6'd12) begin
      w9[30] = 1'b1;
    end
    if ((it3_q.second_of_day >= 17'd43200) && (cfg_i.console_type == 2'd2)) begin
      w9[30] = ~w9[30];
    end

    ver  = cfg_i.game_version;
    base = base_word(cfg_i.console_type != 2'd0, cfg_i.language, ver);

    rnd_d     = '0;
    rnd_d.vld = v3_q;
    rnd_d.ok  = ok;
    rnd_d.a   = Iv0;
    rnd_d.b   = Iv1;
    rnd_d.c   = Iv2;
    rnd_d.d   = Iv3;
    rnd_d.e   = Iv4;
    if (ver[1]) begin
      rnd_d.w[0] = bswap32(seq0_word(cfg_i.language, ver[0]));
      rnd_d.w[1] = bswap32(seq1_word(cfg_i.language, ver[0]));
      rnd_d.w[2] = bswap32(base);
      rnd_d.w[3] = bswap32(base + OffSeq);
      rnd_d.w[4] = bswap32(base + OffSeq);
    end else begin
      rnd_d.w[0] = bswap32(base);
      rnd_d.w[1] = bswap32(base + OffA);
      rnd_d.w[2] = bswap32(base + OffA);
      rnd_d.w[3] = bswap32(base + OffB);
      rnd_d.w[4] = bswap32(base + OffB);
    end
    rnd_d.w[5]  = bswap32({cfg_i.vcount, it3_q.timer_value});
    rnd_d.w[6]  = {16'd0, cfg_i.mac_address[15:0]};
    rnd_d.w[7]  = cfg_i.mac_address[47:16] ^ {1'b0, cfg_i.frame_value, 24'd0} ^
                  {25'd0, cfg_i.status_value};
    rnd_d.w[8]  = {to_bcd(it3_q.year_in_century), to_bcd({3'd0, it3_q.month_number}),
                   to_bcd({2'd0, it3_q.day_of_month}), 5'd0, dow};
    rnd_d.w[9]  = w9;
    rnd_d.w[12] = key;
    rnd_d.w[13] = PadWord;
    rnd_d.w[15] = LenWord;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      rnd_q <= '0;
    end else if (en_i) begin
      v1_q  <= vld_i;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      rnd_q <= rnd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      it1_q   <= item_i;
      hprod_q <= 33'(item_i.second_of_day) * 33'(RecipHour);
      it2_q   <= it1_q;
      hour2_q <= hour_d;
      rem2_q  <= rem_d;
      it3_q   <= it2_q;
      hour3_q <= hour2_q;
      rem3_q  <= rem2_q;
      mprod_q <= 23'(rem2_q) * 23'(RecipMin);
    end
  end

  assign rnd_o = rnd_q;

endmodule

/* hdl/s1tsg_round.sv */
module s1tsg_round
  import s1tsg_pkg::*;
#(
  parameter int unsigned Round = 0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  rnd_t rnd_i,
  output rnd_t rnd_o
);

  rnd_t        rnd_q;
  rnd_t        rnd_d;
  logic [31:0] f, k, nxt;

  always_comb begin
    if (Round < 20) begin
      f = (rnd_i.b & rnd_i.c) | (~rnd_i.b & rnd_i.d);
      k = 32'h5a827999;
    end else if (Round < 40) begin
      f = rnd_i.b ^ rnd_i.c ^ rnd_i.d;
      k = 32'h6ed9eba1;
    end else if (Round < 60) begin
      f = (rnd_i.b & rnd_i.c) | (rnd_i.b & rnd_i.d) | (rnd_i.c & rnd_i.d);
      k = 32'h8f1bbcdc;
    end else begin
      f = rnd_i.b ^ rnd_i.c ^ rnd_i.d;
      k = 32'hca62c1d6;
    end

    // The schedule window slides by one word; the new word is w[i+16].
    nxt = rnd_i.w[13] ^ rnd_i.w[8] ^ rnd_i.w[2] ^ rnd_i.w[0];

    rnd_d        = rnd_i;
    rnd_d.a      = {rnd_i.a[26:0], rnd_i.a[31:27]} + f + rnd_i.e + k + rnd_i.w[0];
    rnd_d.b      = rnd_i.a;
    rnd_d.c      = {rnd_i.b[1:0], rnd_i.b[31:2]};
    rnd_d.d      = rnd_i.c;
    rnd_d.e      = rnd_i.d;
    rnd_d.w      = {{nxt[30:0], nxt[31]}, rnd_i.w[15:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_q <= '0;
    end else if (en_i) begin
      rnd_q <= rnd_d;
    end
  end

  assign rnd_o = rnd_q;

endmodule

/* hdl/s1tsg_lcg.sv */
module s1tsg_lcg
  import s1tsg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  rnd_t        rnd_i,
  output logic        vld_o,
  output logic [63:0] seed_o,
  output logic        ok_o
);

  logic        v1_q, v2_q, v3_q;
  logic        ok1_q, ok2_q, ok3_q;
  logic [63:0] x_q;
  logic [63:0] p0_q;
  logic [31:0] p1_q, p2_q;
  logic [63:0] seed_q;
  logic [63:0] x_d, p0_d, seed_d;
  logic [31:0] p1_d, p2_d, cross_sum;

  always_comb begin
    x_d       = {bswap32(rnd_i.b + Iv1), bswap32(rnd_i.a + Iv0)};
    p0_d      = 64'(x_q[31:0]) * 64'(LcgMul[31:0]);
    p1_d      = x_q[31:0] * LcgMul[63:32];
    p2_d      = x_q[63:32] * LcgMul[31:0];
    cross_sum = p1_q + p2_q;
    seed_d    = ok2_q ? (p0_q + {cross_sum, 32'd0} + LcgAdd) : 64'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= rnd_i.vld;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ok1_q  <= rnd_i.ok;
      x_q    <= x_d;
      ok2_q  <= ok1_q;
      p0_q   <= p0_d;
      p1_q   <= p1_d;
      p2_q   <= p2_d;
      ok3_q  <= ok2_q;
      seed_q <= seed_d;
    end
  end

  assign vld_o  = v3_q;
  assign seed_o = seed_q;
  assign ok_o   = ok3_q;

endmodule

/* hdl/sha1_timestamp_seed_generator.sv */
// Pipeline: 87 registers, the last of which offers the result on the output channel.
// Throughput: one transaction per cycle; the 80 SHA-1 round cells each hold one item.
// The whole pipeline advances together and holds while the result is not taken.
// Reset (asynchronous, active low) clears all valid flags and the configuration.
module sha1_timestamp_seed_generator
  import s1tsg_pkg::*;
#(
  parameter int unsigned CfgIdxWidth  = CfgIdxW,
  parameter int unsigned CfgDataWidth = CfgDataW
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [CfgDataWidth-1:0] cfg_data_i,
  s1tsg_in_if.sink                in_if,
  s1tsg_out_if.source             out_if
);

  // Configuration registers. The user must change them only while no transaction is in
  // flight, which the block does not enforce; the message assembly reads them directly.
  cfg_t  cfg_q;
  item_t item;
  logic  en;
  logic  out_vld;
  rnd_t  chain [NumRounds+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LANGUAGE: cfg_q.language     <= cfg_data_i[2:0];
        REG_VERSION:  cfg_q.game_version <= cfg_data_i[1:0];
        REG_CONSOLE:  cfg_q.console_type <= cfg_data_i[1:0];
        REG_VCOUNT:   cfg_q.vcount       <= cfg_data_i[7:0];
        REG_MAC:      cfg_q.mac_address  <= cfg_data_i[47:0];
        REG_FRAME:    cfg_q.frame_value  <= cfg_data_i[6:0];
        REG_STATUS:   cfg_q.status_value <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // The last stage is the output register; everything moves whenever it is
  // empty or its transaction is being taken.
  assign en          = !out_vld || out_if.ready;
  assign in_if.ready = en;

  assign item.year_in_century = in_if.year_in_century;
  assign item.month_number    = in_if.month_number;
  assign item.day_of_month    = in_if.day_of_month;
  assign item.second_of_day   = in_if.second_of_day;
  assign item.key_mask        = in_if.key_mask;
  assign item.timer_value     = in_if.timer_value;

  // Message assembly: time split, calendar check, weekday and table words.
  s1tsg_msg u_msg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (in_if.valid),
    .item_i (item),
    .cfg_i  (cfg_q),
    .rnd_o  (chain[0])
  );

  // One cell per SHA-1 round, each carrying its own slice of the schedule.
  for (genvar g = 0; g < NumRounds; g++) begin : g_round
    s1tsg_round #(
      .Round (g)
    ) u_round (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .rnd_i  (chain[g]),
      .rnd_o  (chain[g+1])
    );
  end

  // Digest finish, byte swap and the 64-bit LCG step in split products.
  s1tsg_lcg u_lcg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .rnd_i  (chain[NumRounds]),
    .vld_o  (out_vld),
    .seed_o (out_if.seed),
    .ok_o   (out_if.valid_res)
  );

  assign out_if.valid = out_vld;

endmodule

/* verif/seed_checker.sv */
`timescale 1ns / 100ps

// Watches the configuration port and both channels, predicts the seed of every accepted
// candidate and compares each result transaction against the oldest prediction.
module seed_checker
  import s1tsg_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  s1tsg_in_if                 in_mon,
  s1tsg_out_if                out_mon,
  output int                  fail_count_o,
  output int                  pending_o
);

  typedef struct {
    logic [63:0] seed;
    logic        ok;
  } seed_exp_t;

  localparam logic [31:0] BaseOrig [7][4] = '{
    '{32'h022160b0, 32'h022160d0, 32'h02200010, 32'h02200050},
    '{32'h02216070, 32'h02216070, 32'h021fffd0, 32'h021ffff0},
    '{32'h02216030, 32'h02216050, 32'h02200030, 32'h02200050},
    '{32'h02215fb0, 32'h02215fd0, 32'h021fff10, 32'h021fff50},
    '{32'h02215ff0, 32'h02216010, 32'h021fff50, 32'h021fff70},
    '{32'h02215f10, 32'h02215f30, 32'h021ff9b0, 32'h021ff9d0},
    '{32'h022167b0, 32'h022167b0, 32'h02200750, 32'h02200770}};
  localparam logic [31:0] BaseAlt [7][4] = '{
    '{32'h02760190, 32'h027601b0, 32'h027a5f70, 32'h027a5e90},
    '{32'h027601f0, 32'h027601f0, 32'h027a6070, 32'h027a5fb0},
    '{32'h02760230, 32'h02760250, 32'h027a5f90, 32'h027a5ef0},
    '{32'h027601d0, 32'h027601d0, 32'h027a5f70, 32'h027a5ed0},
    '{32'h027602f0, 32'h027602f0, 32'h027a6110, 32'h027a6010},
    '{32'h02761150, 32'h02761150, 32'h027aa730, 32'h027aa5f0},
    '{32'h02761150, 32'h02761150, 32'h02200770, 32'h027a57b0}};
  localparam logic [31:0] SeqA [7][2] = '{
    '{32'h0209aee8, 32'h0209af28}, '{32'h0209aea8, 32'h0209aec8},
    '{32'h0209af08, 32'h0209af28}, '{32'h0209ade8, 32'h0209ae28},
    '{32'h0209ae28, 32'h0209ae48}, '{32'h0209a8dc, 32'h0209a8fc},
    '{32'h0209b60c, 32'h0209b62c}};
  localparam logic [31:0] SeqB [7][2] = '{
    '{32'h02039de9, 32'h02039e15}, '{32'h02039db9, 32'h02039de5},
    '{32'h02039df9, 32'h02039e25}, '{32'h02039d69, 32'h02039d95},
    '{32'h02039d69, 32'h02039d95}, '{32'h02039ac9, 32'h02039af5},
    '{32'h0203a4d5, 32'h0203a501}};

  cfg_t      cfg_copy;
  seed_exp_t seed_queue[$];

  function automatic logic [31:0] swap_bytes(logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  function automatic logic [7:0] bcd(int unsigned v);
    return {4'(v / 10), 4'(v % 10)};
  endfunction

  function automatic seed_exp_t seed_of_moment(item_t it, cfg_t c);
    seed_exp_t   r;
    int unsigned year, len, adj, y, m, jd, hour, secs, lang, ver;
    logic [31:0] w[80];
    logic [31:0] base, key, a, b, cc, d, e, f, k, t;
    logic [63:0] s;
    year = 2000 + it.year_in_century;
    r.ok = it.year_in_century <= 99 && it.month_number >= 1 && it.month_number <= 12 &&
           it.day_of_month >= 1;
    if (r.ok) begin
      case (it.month_number)
        4, 6, 9, 11: len = 30;
        2: len = ((year % 4 == 0 && year % 100 != 0) || year % 400 == 0) ? 29 : 28;
        default: len = 31;
      endcase
      r.ok = it.day_of_month <= len;
    end
    if (!r.ok) begin
      r.seed = '0;
      return r;
    end
    foreach (w[i]) w[i] = '0;
    // Language seven falls back on the last table row.
    lang = c.language <= 6 ? c.language : 6;
    ver  = c.game_version;
    base = c.console_type != 0 ? BaseAlt[lang][ver] : BaseOrig[lang][ver];
    if (ver >= 2) begin
      w[0] = swap_bytes(SeqA[lang][ver-2]);
      w[1] = swap_bytes(SeqB[lang][ver-2]);
      w[2] = swap_bytes(base);
      w[3] = swap_bytes(base + OffSeq);
      w[4] = w[3];
    end else begin
      w[0] = swap_bytes(base);
      w[1] = swap_bytes(base + OffA);
      w[2] = w[1];
      w[3] = swap_bytes(base + OffB);
      w[4] = w[3];
    end
    w[5] = swap_bytes({c.vcount, it.timer_value});
    w[6] = {16'h0, c.mac_address[15:0]};
    w[7] = c.mac_address[47:16] ^ ({25'h0, c.frame_value} << 24) ^ {25'h0, c.status_value};
    adj = it.month_number < 3 ? 1 : 0;
    y = year + 4800 - adj;
    m = it.month_number + 12 * adj - 3;
    jd = it.day_of_month + (153 * m + 2) / 5 + 365 * y + y / 4 - y / 100 + y / 400 - 32045;
    w[8] = {bcd(it.year_in_century), bcd(it.month_number), bcd(it.day_of_month),
            8'((jd + 1) % 7)};
    secs = it.second_of_day;
    hour = secs / 3600;
    w[9] = {bcd(hour), bcd((secs % 3600) / 60), bcd(secs % 60), 8'h0};
    if (hour >= 12) w[9][30] = 1'b1;
    if (secs >= 43200 && c.console_type == 2'd2) w[9][30] = ~w[9][30];
    key = KeyBase;
    for (int i = 0; i < 12; i++)
      if (it.key_mask[i]) key -= i < 4 ? (32'h10000 << i) : (32'h1000000 << (i - 4));
    w[12] = key;
    w[13] = PadWord;
    w[15] = LenWord;
    for (int i = 16; i < 80; i++) begin
      t = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
      w[i] = {t[30:0], t[31]};
    end
    a = Iv0; b = Iv1; cc = Iv2; d = Iv3; e = Iv4;
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & cc) | (~b & d); k = 32'h5a827999;
      end else if (i < 40) begin
        f = b ^ cc ^ d; k = 32'h6ed9eba1;
      end else if (i < 60) begin
        f = (b & cc) | (b & d) | (cc & d); k = 32'h8f1bbcdc;
      end else begin
        f = b ^ cc ^ d; k = 32'hca62c1d6;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w[i];
      e = d; d = cc; cc = {b[1:0], b[31:2]}; b = a; a = t;
    end
    s = {swap_bytes(b + Iv1), swap_bytes(a + Iv0)};
    r.seed = s * LcgMul + LcgAdd;
    return r;
  endfunction

  assign pending_o = seed_queue.size();

  always @(posedge clk_i or negedge rst_ni) begin
    seed_exp_t exp_r;
    item_t     it;
    if (!rst_ni) begin
      cfg_copy     <= '0;
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_LANGUAGE: cfg_copy.language     <= cfg_data_i[2:0];
          REG_VERSION:  cfg_copy.game_version <= cfg_data_i[1:0];
          REG_CONSOLE:  cfg_copy.console_type <= cfg_data_i[1:0];
          REG_VCOUNT:   cfg_copy.vcount       <= cfg_data_i[7:0];
          REG_MAC:      cfg_copy.mac_address  <= cfg_data_i[47:0];
          REG_FRAME:    cfg_copy.frame_value  <= cfg_data_i[6:0];
          REG_STATUS:   cfg_copy.status_value <= cfg_data_i[6:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        it = '{in_mon.year_in_century, in_mon.month_number, in_mon.day_of_month,
               in_mon.second_of_day, in_mon.key_mask, in_mon.timer_value};
        seed_queue.insert(seed_queue.size(), seed_of_moment(it, cfg_copy));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (seed_queue.size() == 0) begin
          $error("result transaction with no candidate outstanding");
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = seed_queue.pop_front();
          if (out_mon.seed !== exp_r.seed || out_mon.valid_res !== exp_r.ok) begin
            if (out_mon.seed !== exp_r.seed)
              $error("seed: expected %h, actual %h", exp_r.seed, out_mon.seed);
            if (out_mon.valid_res !== exp_r.ok)
              $error("valid_res: expected %b, actual %b", exp_r.ok, out_mon.valid_res);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps

// Top of the seed generator testbench. It drives configuration and candidate
// transactions, shapes the back-pressure on the result channel, and gives the verdict.
// All prediction and comparison live in the checker instantiated beside the block.
module testbench;
  import s1tsg_pkg::*;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  int                  fail_count;
  int                  pending;
  int                  send_idle_pct;
  int                  take_stall_pct;

  s1tsg_in_if  in_bus();
  s1tsg_out_if out_bus();

  sha1_timestamp_seed_generator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_bus),
    .out_if     (out_bus)
  );

  seed_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_mon       (in_bus),
    .out_mon      (out_bus),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // The receiver decides at every falling edge whether it takes a result in the next cycle.
  initial out_bus.ready = 1'b0;
  always @(negedge clk_i) begin
    out_bus.ready <= ($urandom_range(99) >= take_stall_pct);
  end

  // A generous guard: even with both sides idling heavily the run needs well under a
  // tenth of this.
  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

  // Writes one register; called at a falling edge, returns at the next falling edge.
  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
  endtask

  task automatic write_all(cfg_t c);
    write_reg(REG_LANGUAGE, CfgDataW'(c.language));
    write_reg(REG_VERSION,  CfgDataW'(c.game_version));
    write_reg(REG_CONSOLE,  CfgDataW'(c.console_type));
    write_reg(REG_VCOUNT,   CfgDataW'(c.vcount));
    write_reg(REG_MAC,      c.mac_address);
    write_reg(REG_FRAME,    CfgDataW'(c.frame_value));
    write_reg(REG_STATUS,   CfgDataW'(c.status_value));
  endtask

  // Offers one candidate, after a random number of idle cycles, and holds it until the
  // block accepts the transaction. Valid stays high afterwards unless a gap follows.
  task automatic offer_candidate(item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid = 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid           = 1'b1;
    in_bus.year_in_century = it.year_in_century;
    in_bus.month_number    = it.month_number;
    in_bus.day_of_month    = it.day_of_month;
    in_bus.second_of_day   = it.second_of_day;
    in_bus.key_mask        = it.key_mask;
    in_bus.timer_value     = it.timer_value;
    do @(posedge clk_i); while (!in_bus.ready);
    @(negedge clk_i);
  endtask

  // Lets the pipeline drain completely; the block yields one result per candidate, so
  // an empty prediction store means it is idle.
  task automatic drain_pipeline();
    in_bus.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic item_t make_candidate(logic [6:0] yr, logic [3:0] mo, logic [4:0] dy,
                                           logic [16:0] sec, logic [11:0] keys,
                                           logic [15:0] tmr);
    item_t it;
    it = '{yr, mo, dy, sec, keys, tmr};
    return it;
  endfunction

  // Mostly genuine calendar dates with random content, the rest raw field noise that
  // covers bad months, bad days, years past the century and seconds past midnight.
  function automatic item_t random_candidate();
    item_t       it;
    int unsigned len, yr;
    it.key_mask    = 12'($urandom);
    it.timer_value = 16'($urandom);
    if ($urandom_range(99) < 80) begin
      yr = $urandom_range(99);
      it.year_in_century = 7'(yr);
      it.month_number    = 4'($urandom_range(1, 12));
      case (it.month_number)
        4, 6, 9, 11: len = 30;
        2: len = (yr % 4 == 0) ? 29 : 28;
        default: len = 31;
      endcase
      it.day_of_month  = 5'($urandom_range(1, len));
      it.second_of_day = 17'($urandom_range(86399));
    end else begin
      it.year_in_century = 7'($urandom);
      it.month_number    = 4'($urandom);
      it.day_of_month    = 5'($urandom);
      it.second_of_day   = 17'($urandom);
    end
    return it;
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.language     = 3'($urandom);
    c.game_version = 2'($urandom);
    c.console_type = 2'($urandom);
    c.vcount       = 8'($urandom);
    c.mac_address  = {16'($urandom), 32'($urandom)};
    c.frame_value  = 7'($urandom);
    c.status_value = 7'($urandom);
    return c;
  endfunction

  initial begin
    cfg_t  c;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_data_i      = '0;
    in_bus.valid    = 1'b0;
    in_bus.year_in_century = '0;
    in_bus.month_number    = '0;
    in_bus.day_of_month    = '0;
    in_bus.second_of_day   = '0;
    in_bus.key_mask        = '0;
    in_bus.timer_value     = '0;
    send_idle_pct   = 0;
    take_stall_pct  = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed candidates against the reset configuration: date and time extremes, the
    // leap rules, every kind of invalid date, the noon boundary and a second past the
    // end of the day, all keys held and none.
    offer_candidate(make_candidate(7'd0,   4'd1,  5'd1,  17'd0,      12'h000, 16'h0000));
    offer_candidate(make_candidate(7'd99,  4'd12, 5'd31, 17'd86399,  12'hfff, 16'hffff));
    offer_candidate(make_candidate(7'd0,   4'd2,  5'd29, 17'd43199,  12'h001, 16'h1234));
    offer_candidate(make_candidate(7'd1,   4'd2,  5'd29, 17'd43200,  12'h800, 16'h0001));
    offer_candidate(make_candidate(7'd4,   4'd2,  5'd29, 17'd43200,  12'h00f, 16'h8000));
    offer_candidate(make_candidate(7'd100, 4'd1,  5'd1,  17'd100,    12'h0f0, 16'h00ff));
    offer_candidate(make_candidate(7'd127, 4'd15, 5'd31, 17'h1ffff,  12'hfff, 16'hffff));
    offer_candidate(make_candidate(7'd50,  4'd0,  5'd10, 17'd500,    12'h555, 16'haaaa));
    offer_candidate(make_candidate(7'd50,  4'd13, 5'd10, 17'd500,    12'haaa, 16'h5555));
    offer_candidate(make_candidate(7'd50,  4'd6,  5'd0,  17'd500,    12'h123, 16'h4321));
    offer_candidate(make_candidate(7'd50,  4'd4,  5'd31, 17'd500,    12'h321, 16'h0f0f));
    offer_candidate(make_candidate(7'd50,  4'd4,  5'd30, 17'd500,    12'h010, 16'hf0f0));
    offer_candidate(make_candidate(7'd23,  4'd1,  5'd31, 17'h1ffff,  12'h100, 16'h7fff));
    offer_candidate(make_candidate(7'd64,  4'd8,  5'd16, 17'd86400,  12'h080, 16'h0100));
    offer_candidate(make_candidate(7'd77,  4'd11, 5'd30, 17'd129599, 12'h040, 16'h0010));
    drain_pipeline();

    // Phases with different settings and idling patterns. The first two settings are
    // the extremes: every register at its largest code, then all back to zero.
    for (int phase = 0; phase < 12; phase++) begin
      if (phase == 0) c = '1;
      else if (phase == 1) c = '0;
      else begin
        c = random_cfg();
        if (phase % 3 == 0) c.console_type = 2'd2;
      end
      write_all(c);
      case (phase % 4)
        0: begin send_idle_pct = 0;  take_stall_pct = 0;  end
        1: begin send_idle_pct = 61; take_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  take_stall_pct = 61; end
        default: begin send_idle_pct = 29; take_stall_pct = 29; end
      endcase
      for (int n = 0; n < 120; n++) begin
        offer_candidate(random_candidate());
        // Occasionally hold off until every outstanding result has come back.
        if (n == 60 && phase % 5 == 2) drain_pipeline();
      end
      drain_pipeline();
    end

    take_stall_pct = 0;
    repeat (120) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/s1tsg_pkg.sv
hdl/s1tsg_if.sv
hdl/s1tsg_msg.sv
hdl/s1tsg_round.sv
hdl/s1tsg_lcg.sv
hdl/sha1_timestamp_seed_generator.sv
verif/seed_checker.sv
verif/testbench.sv
